// ===== rtl/kst_pkg.sv =====
// Shared types and constants for the keyed session table.
// Used by kst_store and keyed_session_table; depends on nothing.
package kst_pkg;

    localparam int CAPACITY = 64;            // entries, 1 to 64
    localparam int IDX_W    = 6;             // position width
    localparam int CNT_W    = 7;             // fill count width, holds CAPACITY

    localparam int KEY_A_W  = 64;
    localparam int KEY_B_W  = 64;
    localparam int KEY_C_W  = 24;
    localparam int SOCK_W   = 16;

    localparam logic [2:0] MODE_ADD         = 3'd0;
    localparam logic [2:0] MODE_LOOKUP_SOCK = 3'd1;
    localparam logic [2:0] MODE_LOOKUP_POS  = 3'd2;
    localparam logic [2:0] MODE_REMOVE      = 3'd3;
    localparam logic [2:0] MODE_LIST        = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [KEY_A_W-1:0] a;
        logic [KEY_B_W-1:0] b;
        logic [KEY_C_W-1:0] c;
    } key_t;

    typedef struct packed {
        key_t              key;
        logic [SOCK_W-1:0] sock;
    } entry_t;

endpackage

// ===== rtl/kst_store.sv =====
// Entry memory of the session table: one write port, one registered read port,
// and the key comparator on the read data. Depends on kst_pkg.
module kst_store (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [kst_pkg::IDX_W-1:0] wr_addr,
    input  kst_pkg::entry_t          wr_data,
    input  logic [kst_pkg::IDX_W-1:0] rd_addr,
    output kst_pkg::entry_t          rd_data,
    input  kst_pkg::key_t            key,
    output logic                     key_match
);

    kst_pkg::entry_t mem [kst_pkg::CAPACITY];
    kst_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data   = rd_data_reg;
    // all three key words
    assign key_match = (rd_data_reg.key == key);

endmodule

// ===== rtl/keyed_session_table.sv =====
// Keyed session table top level: request sequencer, fill count and result register.
// Depends on kst_pkg and kst_store.
//
// A dense table of up to 64 sessions (name key plus socket). Requests are taken
// one at a time; a request is accepted only when the sequencer is idle, but a
// finished result may still sit in the output register. All work goes through
// the single read port of the entry memory, one entry per cycle: add and both
// lookups scan in order; remove scans the same way and then adds a shift-down
// pass over the entries above the match; list emits one result per cycle while
// the consumer keeps m_ready high, after a read start. Modes 5 to 7 are dropped
// without a result. Nothing is cleared at reset beyond the state, the count,
// the pending flag and the output valid.
module keyed_session_table (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [63:0] s_key_word_a,
    input  logic [63:0] s_key_word_b,
    input  logic [23:0] s_key_word_c,
    input  logic [15:0] s_socket_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_socket_out,
    output logic [5:0]  m_position_out,
    output logic [6:0]  m_entry_count,
    output logic [63:0] m_name_out_a,
    output logic [63:0] m_name_out_b,
    output logic [23:0] m_name_out_c,
    output logic        m_entry_valid,
    output logic        m_last
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_LIST   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [kst_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic [kst_pkg::CNT_W-1:0]  scan_reg, scan_next;   // next address to read
    logic                       pend_reg, pend_next;   // read data of pidx is valid
    logic [kst_pkg::IDX_W-1:0]  pidx_reg, pidx_next;

    logic [2:0]                 mode_reg, mode_next;
    kst_pkg::key_t              key_reg, key_next;
    logic [kst_pkg::SOCK_W-1:0] sock_reg, sock_next;

    logic [1:0]                 res_status_reg, res_status_next;
    logic [kst_pkg::SOCK_W-1:0] res_sock_reg, res_sock_next;
    logic [kst_pkg::IDX_W-1:0]  res_pos_reg, res_pos_next;

    logic                       o_valid_reg, o_valid_next;
    logic [1:0]                 o_status_reg, o_status_next;
    logic [kst_pkg::SOCK_W-1:0] o_sock_reg, o_sock_next;
    logic [kst_pkg::IDX_W-1:0]  o_pos_reg, o_pos_next;
    logic [kst_pkg::CNT_W-1:0]  o_count_reg, o_count_next;
    kst_pkg::key_t              o_name_reg, o_name_next;
    logic                       o_entry_valid_reg, o_entry_valid_next;
    logic                       o_last_reg, o_last_next;

    logic                       wr_en;
    logic [kst_pkg::IDX_W-1:0]  wr_addr;
    kst_pkg::entry_t            wr_data;
    logic [kst_pkg::IDX_W-1:0]  rd_addr;
    kst_pkg::entry_t            rd_data;
    logic                       key_match;
    logic                       out_free;
    logic [kst_pkg::CNT_W-1:0]  scan_inc;

    kst_store u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .key       (key_reg),
        .key_match (key_match)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !o_valid_reg || m_ready;
    assign scan_inc = scan_reg + kst_pkg::CNT_W'(1);

    always_comb begin
        state_next         = state_reg;
        fill_next          = fill_reg;
        scan_next          = scan_reg;
        pend_next          = pend_reg;
        pidx_next          = pidx_reg;
        mode_next          = mode_reg;
        key_next           = key_reg;
        sock_next          = sock_reg;
        res_status_next    = res_status_reg;
        res_sock_next      = res_sock_reg;
        res_pos_next       = res_pos_reg;
        o_valid_next       = o_valid_reg && !m_ready;
        o_status_next      = o_status_reg;
        o_sock_next        = o_sock_reg;
        o_pos_next         = o_pos_reg;
        o_count_next       = o_count_reg;
        o_name_next        = o_name_reg;
        o_entry_valid_next = o_entry_valid_reg;
        o_last_next        = o_last_reg;
        wr_en              = 1'b0;
        wr_addr            = pidx_reg - kst_pkg::IDX_W'(1);
        wr_data            = rd_data;
        rd_addr            = scan_reg[kst_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next       = s_mode;
                    key_next.a      = s_key_word_a;
                    key_next.b      = s_key_word_b;
                    key_next.c      = s_key_word_c;
                    sock_next       = s_socket_in;
                    scan_next       = '0;
                    pend_next       = 1'b0;
                    res_status_next = kst_pkg::ST_OK;
                    res_sock_next   = '0;
                    res_pos_next    = '0;
                    case (s_mode)
                        kst_pkg::MODE_ADD: begin
                            if (fill_reg >= kst_pkg::CNT_W'(kst_pkg::CAPACITY)) begin
                                res_status_next = kst_pkg::ST_FULL;
                                state_next      = S_FINISH;
                            end else begin
                                state_next = S_SEARCH;
                            end
                        end
                        kst_pkg::MODE_LOOKUP_SOCK, kst_pkg::MODE_LOOKUP_POS,
                        kst_pkg::MODE_REMOVE: begin
                            state_next = S_SEARCH;
                        end
                        kst_pkg::MODE_LIST: begin
                            state_next = (fill_reg == '0) ? S_FINISH : S_LIST;
                        end
                        default: begin
                            state_next = S_IDLE;   // unused mode: no result
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                if (pend_reg && key_match) begin
                    res_pos_next = pidx_reg;
                    pend_next    = 1'b0;
                    if (mode_reg == kst_pkg::MODE_ADD) begin
                        res_status_next = kst_pkg::ST_DUPLICATE;
                        state_next      = S_FINISH;
                    end else if (mode_reg == kst_pkg::MODE_REMOVE) begin
                        res_sock_next = rd_data.sock;
                        scan_next     = {1'b0, pidx_reg} + kst_pkg::CNT_W'(1);
                        state_next    = S_SHIFT;
                    end else begin
                        res_sock_next = rd_data.sock;
                        state_next    = S_FINISH;
                    end
                end else if (scan_reg == fill_reg) begin
                    pend_next = 1'b0;
                    if (mode_reg == kst_pkg::MODE_ADD) begin
                        // append at the end of the table
                        wr_en         = 1'b1;
                        wr_addr       = fill_reg[kst_pkg::IDX_W-1:0];
                        wr_data.key   = key_reg;
                        wr_data.sock  = sock_reg;
                        fill_next     = fill_reg + kst_pkg::CNT_W'(1);
                        res_pos_next  = fill_reg[kst_pkg::IDX_W-1:0];
                    end else begin
                        res_status_next = kst_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_FINISH;
                end else begin
                    pend_next = 1'b1;
                    pidx_next = scan_reg[kst_pkg::IDX_W-1:0];
                    scan_next = scan_inc;
                end
            end

            S_SHIFT: begin
                // entry read last cycle moves down one slot
                wr_en = pend_reg;
                if (scan_reg < fill_reg) begin
                    pend_next = 1'b1;
                    pidx_next = scan_reg[kst_pkg::IDX_W-1:0];
                    scan_next = scan_inc;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        fill_next  = fill_reg - kst_pkg::CNT_W'(1);
                        state_next = S_FINISH;
                    end
                end
            end

            S_LIST: begin
                if (pend_reg && out_free) begin
                    o_valid_next       = 1'b1;
                    o_status_next      = kst_pkg::ST_OK;
                    o_sock_next        = rd_data.sock;
                    o_pos_next         = scan_reg[kst_pkg::IDX_W-1:0];
                    o_count_next       = fill_reg;
                    o_name_next        = rd_data.key;
                    o_entry_valid_next = 1'b1;
                    o_last_next        = (scan_inc == fill_reg);
                    rd_addr            = scan_inc[kst_pkg::IDX_W-1:0];
                    scan_next          = scan_inc;
                    pend_next          = (scan_inc < fill_reg);
                    if (scan_inc == fill_reg) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    pend_next = 1'b1;
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    o_valid_next       = 1'b1;
                    o_status_next      = res_status_reg;
                    o_sock_next        = res_sock_reg;
                    o_pos_next         = res_pos_reg;
                    o_count_next       = fill_reg;
                    o_name_next        = '0;
                    o_entry_valid_next = 1'b0;
                    o_last_next        = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg          <= scan_next;
        pidx_reg          <= pidx_next;
        mode_reg          <= mode_next;
        key_reg           <= key_next;
        sock_reg          <= sock_next;
        res_status_reg    <= res_status_next;
        res_sock_reg      <= res_sock_next;
        res_pos_reg       <= res_pos_next;
        o_status_reg      <= o_status_next;
        o_sock_reg        <= o_sock_next;
        o_pos_reg         <= o_pos_next;
        o_count_reg       <= o_count_next;
        o_name_reg        <= o_name_next;
        o_entry_valid_reg <= o_entry_valid_next;
        o_last_reg        <= o_last_next;
    end

    assign m_valid        = o_valid_reg;
    assign m_status       = o_status_reg;
    assign m_socket_out   = o_sock_reg;
    assign m_position_out = o_pos_reg;
    assign m_entry_count  = o_count_reg;
    assign m_name_out_a   = o_name_reg.a;
    assign m_name_out_b   = o_name_reg.b;
    assign m_name_out_c   = o_name_reg.c;
    assign m_entry_valid  = o_entry_valid_reg;
    assign m_last         = o_last_reg;

endmodule
